FILE: hw/rtl/htg_pkg.sv
// ----------------------------------------------------------------------------
// htg_pkg
// Types and fixed widths shared by the hit time grouping block.
// ----------------------------------------------------------------------------
package htg_pkg;

   localparam int TIME_W      = 32;
   localparam int WIN_W       = 31;
   localparam int GROUP_W     = 6;
   localparam int OUT_IDX_W   = 5;
   localparam int MAX_RESULTS = 32;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 31'd100;

   // per-hit bookkeeping held beside the time store
   typedef struct packed {
      logic               good;
      logic               grouped;
      logic [GROUP_W-1:0] group;
   } hit_info_type;

   // running outcome of a group search
   typedef struct packed {
      logic               found;
      logic [GROUP_W-1:0] group;
   } match_type;

endpackage

FILE: hw/rtl/htg_ram.sv
// ----------------------------------------------------------------------------
// htg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module htg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold the last read when not enabled
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/htg_match.sv
// ----------------------------------------------------------------------------
// htg_match
// Shared time window compare with a running minimum of matching group numbers.
// ----------------------------------------------------------------------------
module htg_match (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic                                valid,
   input  htg_pkg::hit_info_type               cand,
   input  logic signed [htg_pkg::TIME_W-1:0]   time_a,
   input  logic signed [htg_pkg::TIME_W-1:0]   time_b,
   input  logic [htg_pkg::WIN_W-1:0]           window,
   output htg_pkg::match_type                  result
);
   import htg_pkg::*;

   localparam int DIFF_W = TIME_W + 2;

   logic signed [DIFF_W-1:0] a_ext;
   logic signed [DIFF_W-1:0] b_ext;
   logic signed [DIFF_W-1:0] w_ext;
   logic signed [DIFF_W-1:0] d_ab;
   logic signed [DIFF_W-1:0] d_ba;
   logic                     close;
   logic                     take;
   match_type                result_ff;
   match_type                result_in;

   assign a_ext = {{2{time_a[TIME_W-1]}}, time_a};
   assign b_ext = {{2{time_b[TIME_W-1]}}, time_b};
   assign w_ext = $signed({{(DIFF_W-WIN_W){1'b0}}, window});

   // |a - b| < w  <=>  a - b - w < 0 and b - a - w < 0
   assign d_ab  = a_ext - b_ext - w_ext;
   assign d_ba  = b_ext - a_ext - w_ext;
   assign close = d_ab[DIFF_W-1] && d_ba[DIFF_W-1];

   assign take = valid && cand.grouped && close &&
                 (!result_ff.found || (cand.group < result_ff.group));

   always_comb begin
      result_in = result_ff;
      if (clear) begin
         result_in.found = 1'b0;
         result_in.group = '0;
      end else if (take) begin
         result_in.found = 1'b1;
         result_in.group = cand.group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
      end else begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

FILE: hw/rtl/hit_time_grouping.sv
// ----------------------------------------------------------------------------
// hit_time_grouping
// A stored bad hit or a dropped hit that does not end the frame is taken and
// busy stays low. A good hit at position i holds busy while it is compared with
// the earlier hits, one compare per cycle on the shared unit.
// Frame end: a pass reads back every stored hit and compares each bad hit with
// all stored hits, then gives one result per cycle; no stall.
// Synchronous reset clears counters and state; the stores are not cleared.
// ----------------------------------------------------------------------------
module hit_time_grouping #(
   parameter int MAX_HITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [htg_pkg::TIME_W-1:0]   req_hit_time,
   input  logic                                req_good_baseline,
   input  logic                                req_frame_end,
   input  logic                                csr_wr_en,
   input  logic [htg_pkg::WIN_W-1:0]           csr_wr_data,
   output logic                                rsp_valid,
   output logic [htg_pkg::OUT_IDX_W-1:0]       rsp_hit_index,
   output logic [htg_pkg::OUT_IDX_W-1:0]       rsp_group_number,
   output logic                                rsp_grouped,
   output logic                                rsp_overflow,
   output logic                                rsp_last_result
);
   import htg_pkg::*;

   localparam int IDX_W  = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CNT_W  = $clog2(MAX_HITS + 1);
   localparam int INFO_W = $bits(hit_info_type);
   localparam int N_LIM  = (MAX_HITS < MAX_RESULTS) ? MAX_HITS : MAX_RESULTS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_BAD_RD,
      S_BAD_CHK,
      S_OUT,
      S_DRAIN
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          hit_count_ff, hit_count_in;
   logic [CNT_W-1:0]          group_count_ff, group_count_in;
   logic                      overflow_ff, overflow_in;
   logic [WIN_W-1:0]          window_ff, window_in;
   logic signed [TIME_W-1:0]  cur_time_ff, cur_time_in;
   logic [IDX_W-1:0]          cur_idx_ff, cur_idx_in;
   logic                      end_ff, end_in;
   logic                      bad_mode_ff, bad_mode_in;
   logic [CNT_W-1:0]          issue_ff, issue_in;
   logic [CNT_W-1:0]          limit_ff, limit_in;
   logic [CNT_W-1:0]          bad_idx_ff, bad_idx_in;
   logic                      pipe_valid_ff, pipe_valid_in;
   logic                      out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]          out_idx_ff, out_idx_in;
   logic                      out_last_ff, out_last_in;

   logic                      accept;
   logic [CNT_W-1:0]          n_results;
   logic                      match_clear;
   match_type                 match;

   logic                      time_wr_en;
   logic                      info_wr_en;
   logic [IDX_W-1:0]          info_wr_addr;
   hit_info_type              info_wr_data;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic signed [TIME_W-1:0]  time_rdata;
   logic [INFO_W-1:0]         info_rdata_raw;
   hit_info_type              info_rdata;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign n_results = (hit_count_ff > CNT_W'(N_LIM)) ? CNT_W'(N_LIM) : hit_count_ff;
   assign info_rdata = hit_info_type'(info_rdata_raw);

   htg_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_HITS)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (time_wr_en),
      .wr_addr (hit_count_ff[IDX_W-1:0]),
      .wr_data (req_hit_time),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (time_rdata)
   );

   htg_ram #(
      .WIDTH (INFO_W),
      .DEPTH (MAX_HITS)
   ) u_info_ram (
      .clock   (clock),
      .wr_en   (info_wr_en),
      .wr_addr (info_wr_addr),
      .wr_data (info_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (info_rdata_raw)
   );

   htg_match u_match (
      .clock  (clock),
      .reset  (reset),
      .clear  (match_clear),
      .valid  (pipe_valid_ff),
      .cand   (info_rdata),
      .time_a (cur_time_ff),
      .time_b (time_rdata),
      .window (window_ff),
      .result (match)
   );

   always_comb begin
      state_in       = state_ff;
      hit_count_in   = hit_count_ff;
      group_count_in = group_count_ff;
      overflow_in    = overflow_ff;
      window_in      = window_ff;
      cur_time_in    = cur_time_ff;
      cur_idx_in     = cur_idx_ff;
      end_in         = end_ff;
      bad_mode_in    = bad_mode_ff;
      issue_in       = issue_ff;
      limit_in       = limit_ff;
      bad_idx_in     = bad_idx_ff;
      pipe_valid_in  = 1'b0;
      out_valid_in   = 1'b0;
      out_idx_in     = out_idx_ff;
      out_last_in    = out_last_ff;
      match_clear    = 1'b0;
      time_wr_en     = 1'b0;
      info_wr_en     = 1'b0;
      info_wr_addr   = hit_count_ff[IDX_W-1:0];
      info_wr_data   = '0;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[IDX_W-1:0];

      if (csr_wr_en) begin
         window_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               end_in = req_frame_end;
               if (hit_count_ff < CNT_W'(MAX_HITS)) begin
                  time_wr_en           = 1'b1;
                  info_wr_en           = 1'b1;
                  info_wr_data.good    = req_good_baseline;
                  hit_count_in         = hit_count_ff + 1'b1;
                  cur_idx_in           = hit_count_ff[IDX_W-1:0];
                  cur_time_in          = req_hit_time;
                  if (req_good_baseline) begin
                     // search earlier hits only
                     limit_in    = hit_count_ff;
                     issue_in    = '0;
                     bad_mode_in = 1'b0;
                     match_clear = 1'b1;
                     state_in    = S_SCAN;
                  end else if (req_frame_end) begin
                     bad_idx_in = '0;
                     state_in   = S_BAD_RD;
                  end
               end else begin
                  overflow_in = 1'b1;
                  if (req_frame_end) begin
                     bad_idx_in = '0;
                     state_in   = S_BAD_RD;
                  end
               end
            end
         end

         S_SCAN: begin
            if (issue_ff < limit_ff) begin
               rd_en         = 1'b1;
               issue_in      = issue_ff + 1'b1;
               pipe_valid_in = 1'b1;
            end else if (!pipe_valid_ff) begin
               info_wr_en           = 1'b1;
               info_wr_data.grouped = 1'b1;
               info_wr_data.group   = match.group;
               if (bad_mode_ff) begin
                  // leave an unmatched bad hit as stored
                  info_wr_en   = match.found;
                  info_wr_addr = bad_idx_ff[IDX_W-1:0];
                  bad_idx_in   = bad_idx_ff + 1'b1;
                  state_in     = S_BAD_RD;
               end else begin
                  info_wr_addr      = cur_idx_ff;
                  info_wr_data.good = 1'b1;
                  if (!match.found) begin
                     info_wr_data.group = GROUP_W'(group_count_ff);
                     group_count_in     = group_count_ff + 1'b1;
                  end
                  if (end_ff) begin
                     bad_idx_in = '0;
                     state_in   = S_BAD_RD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end

         S_BAD_RD: begin
            if (bad_idx_ff < hit_count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = bad_idx_ff[IDX_W-1:0];
               state_in = S_BAD_CHK;
            end else begin
               issue_in = '0;
               state_in = S_OUT;
            end
         end

         S_BAD_CHK: begin
            if (info_rdata.good) begin
               bad_idx_in = bad_idx_ff + 1'b1;
               state_in   = S_BAD_RD;
            end else begin
               // the hit itself is ungrouped, so the scan skips it
               cur_time_in = time_rdata;
               limit_in    = hit_count_ff;
               issue_in    = '0;
               bad_mode_in = 1'b1;
               match_clear = 1'b1;
               state_in    = S_SCAN;
            end
         end

         S_OUT: begin
            if (issue_ff < n_results) begin
               rd_en        = 1'b1;
               issue_in     = issue_ff + 1'b1;
               out_valid_in = 1'b1;
               out_idx_in   = issue_ff[IDX_W-1:0];
               out_last_in  = ((issue_ff + 1'b1) == n_results);
               if ((issue_ff + 1'b1) == n_results) begin
                  state_in = S_DRAIN;
               end
            end else begin
               state_in = S_DRAIN;
            end
         end

         S_DRAIN: begin
            // last transaction is on the result ports in this cycle
            hit_count_in   = '0;
            group_count_in = '0;
            overflow_in    = 1'b0;
            state_in       = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_time_ff <= cur_time_in;
      cur_idx_ff  <= cur_idx_in;
      end_ff      <= end_in;
      bad_mode_ff <= bad_mode_in;
      issue_ff    <= issue_in;
      limit_ff    <= limit_in;
      bad_idx_ff  <= bad_idx_in;
      out_idx_ff  <= out_idx_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         hit_count_ff   <= '0;
         group_count_ff <= '0;
         overflow_ff    <= 1'b0;
         window_ff      <= WINDOW_RESET;
         pipe_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hit_count_ff   <= hit_count_in;
         group_count_ff <= group_count_in;
         overflow_ff    <= overflow_in;
         window_ff      <= window_in;
         pipe_valid_ff  <= pipe_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_hit_index    = OUT_IDX_W'(out_idx_ff);
   assign rsp_grouped      = info_rdata.grouped;
   assign rsp_group_number = info_rdata.grouped ? info_rdata.group[OUT_IDX_W-1:0] : '0;
   assign rsp_overflow     = overflow_ff;
   assign rsp_last_result  = out_last_ff;

`ifndef SYNTHESIS
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy frame");

   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |=> (!rsp_valid && !busy && hit_count_ff == '0))
      else $error("frame not closed after final result");

   a_hit_count_bound: assert property (@(posedge clock) disable iff (reset)
      hit_count_ff <= CNT_W'(MAX_HITS))
      else $error("hit count beyond capacity");

   a_groups_bound: assert property (@(posedge clock) disable iff (reset)
      group_count_ff <= hit_count_ff)
      else $error("more groups than stored hits");
`endif

endmodule

FILE: sim/hit_time_grouping_test.sv
// ----------------------------------------------------------------------------
// hit_time_grouping_test
// Self-checking bench for the hit time grouping block. Frames of hits are
// driven through the start/busy handshake under several window settings and
// sender gap rates. A scoreboard regroups every frame on its own and checks
// each strobed result against the oldest expected one.
// ----------------------------------------------------------------------------
module hit_time_grouping_test;
   import htg_pkg::*;

   localparam int MAX_HITS    = 32;
   localparam int STALL_LIMIT = 10000;

   localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;
   localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7FFF_FFFF;
   localparam logic [WIN_W-1:0]         WIN_MAX  = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] hit_index;
      logic [OUT_IDX_W-1:0] group_number;
      logic                 grouped;
      logic                 overflow;
      logic                 last_result;
   } hit_result_type;

   class grouping_tracker_type;
      logic [WIN_W-1:0]          window;
      logic signed [TIME_W-1:0]  times [MAX_HITS];
      bit                        good [MAX_HITS];
      int                        grp [MAX_HITS];
      bit                        grouped [MAX_HITS];
      int                        hit_count;
      int                        group_count;
      bit                        overflow;
      hit_result_type            pending_results [$];
      int                        failures;

      function new();
         window      = WINDOW_RESET;
         hit_count   = 0;
         group_count = 0;
         overflow    = 0;
         failures    = 0;
      endfunction

      function bit close_in_time(logic signed [TIME_W-1:0] a, logic signed [TIME_W-1:0] b);
         longint d;
         d = longint'(a) - longint'(b);
         if (d < 0) d = -d;
         return d < longint'({1'b0, window});
      endfunction

      // first group in creation order holding a member near hit i
      function int find_group(int i);
         for (int g = 0; g < group_count; g++) begin
            for (int k = 0; k < hit_count; k++) begin
               if (k != i && grouped[k] && grp[k] == g && close_in_time(times[i], times[k]))
                  return g;
            end
         end
         return -1;
      endfunction

      function void add_hit(logic signed [TIME_W-1:0] t, bit is_good, bit is_end);
         hit_result_type r;
         int             i;
         int             g;
         int             n;
         if (hit_count < MAX_HITS) begin
            i          = hit_count;
            times[i]   = t;
            good[i]    = is_good;
            grp[i]     = 0;
            grouped[i] = 0;
            hit_count  = i + 1;
            if (is_good) begin
               g = find_group(i);
               if (g < 0) begin
                  grp[i] = group_count & 63;
                  group_count++;
               end else begin
                  grp[i] = g;
               end
               grouped[i] = 1;
            end
         end else begin
            overflow = 1;
         end
         if (!is_end) return;

         // place bad-baseline hits, earlier placements count as members
         for (i = 0; i < hit_count; i++) begin
            if (!good[i]) begin
               g = find_group(i);
               if (g >= 0) begin
                  grp[i]     = g;
                  grouped[i] = 1;
               end
            end
         end

         n = (hit_count < MAX_RESULTS) ? hit_count : MAX_RESULTS;
         for (i = 0; i < n; i++) begin
            r.hit_index    = OUT_IDX_W'(i);
            r.group_number = grouped[i] ? OUT_IDX_W'(grp[i]) : '0;
            r.grouped      = grouped[i];
            r.overflow     = overflow;
            r.last_result  = (i + 1 == n);
            pending_results.insert(pending_results.size(), r);
         end
         hit_count   = 0;
         group_count = 0;
         overflow    = 0;
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      function void check_result(hit_result_type got);
         hit_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result: index %0d group %0d grouped %0b",
                             got.hit_index, got.group_number, got.grouped));
            return;
         end
         want = pending_results.pop_front();
         if (got.hit_index !== want.hit_index || got.group_number !== want.group_number ||
             got.grouped !== want.grouped || got.overflow !== want.overflow ||
             got.last_result !== want.last_result)
            report($sformatf({"result mismatch: expected idx %0d grp %0d in %0b ovf %0b last %0b,",
                              " got idx %0d grp %0d in %0b ovf %0b last %0b"},
                             want.hit_index, want.group_number, want.grouped,
                             want.overflow, want.last_result,
                             got.hit_index, got.group_number, got.grouped,
                             got.overflow, got.last_result));
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic signed [TIME_W-1:0]   req_hit_time;
   logic                       req_good_baseline;
   logic                       req_frame_end;
   logic                       csr_wr_en;
   logic [WIN_W-1:0]           csr_wr_data;
   logic                       rsp_valid;
   logic [OUT_IDX_W-1:0]       rsp_hit_index;
   logic [OUT_IDX_W-1:0]       rsp_group_number;
   logic                       rsp_grouped;
   logic                       rsp_overflow;
   logic                       rsp_last_result;

   grouping_tracker_type sb;
   int                   stall_cycles = 0;

   hit_time_grouping #(.MAX_HITS(MAX_HITS)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_hit_time      (req_hit_time),
      .req_good_baseline (req_good_baseline),
      .req_frame_end     (req_frame_end),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_hit_index     (rsp_hit_index),
      .rsp_group_number  (rsp_group_number),
      .rsp_grouped       (rsp_grouped),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_result   (rsp_last_result)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_result('{rsp_hit_index, rsp_group_number, rsp_grouped,
                           rsp_overflow, rsp_last_result});
   end

   // count cycles in which no transaction moves on either side
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_hit(input logic signed [TIME_W-1:0] t, input bit is_good,
                           input bit is_end, input int idle_pct);
      int gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_hit_time      <= t;
      req_good_baseline <= is_good;
      req_frame_end     <= is_end;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.add_hit(t, is_good, is_end);
   endtask

   // drop start, drain every expected result and let the block go quiet
   task automatic settle();
      start <= 1'b0;
      while (sb.pending_results.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.window = value;
   endtask

   // one frame of clustered hits around a random base time
   task automatic send_frame(input int idle_pct, inout int sent);
      int                       len;
      int                       pick;
      longint                   w;
      longint                   span;
      longint                   off;
      logic signed [TIME_W-1:0] base;
      logic signed [TIME_W-1:0] prev;
      logic signed [TIME_W-1:0] t;
      pick = $urandom_range(0, 99);
      if (pick < 82)      len = $urandom_range(1, 10);
      else if (pick < 92) len = $urandom_range(11, 32);
      else                len = $urandom_range(33, 40);
      w    = longint'({1'b0, sb.window});
      span = (w < 2) ? 4 : 2 * w;
      base = $urandom;
      prev = base;
      for (int k = 0; k < len; k++) begin
         case ($urandom_range(0, 9))
            0: t = $urandom;
            1: begin
               // land on or just inside the window edge of the previous hit
               off = (w > 0) ? w - $urandom_range(0, 1) : 0;
               if ($urandom_range(0, 1)) off = -off;
               t = TIME_W'(longint'(prev) + off);
            end
            default: begin
               off = longint'($urandom_range(0, 32'(span))) - span / 2;
               t = TIME_W'(longint'(base) + off);
            end
         endcase
         send_hit(t, $urandom_range(0, 99) < 70, k == len - 1, idle_pct);
         prev = t;
      end
      sent += len;
   endtask

   initial begin
      int sent;
      int idle_pct;
      sb = new();
      reset             <= 1'b1;
      start             <= 1'b0;
      req_hit_time      <= '0;
      req_good_baseline <= 1'b0;
      req_frame_end     <= 1'b0;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // window at its reset value: joins, exact edge, bad-hit pass
      send_hit(0, 1, 0, 0);
      send_hit(99, 1, 0, 0);
      send_hit(199, 1, 0, 0);
      send_hit(-100, 0, 0, 0);
      send_hit(150, 0, 0, 0);
      send_hit(TIME_MIN, 1, 0, 0);
      send_hit(TIME_MAX, 0, 1, 0);
      send_hit(TIME_MAX, 0, 1, 0);
      send_hit(TIME_MIN, 1, 1, 0);
      settle();

      // zero window: every good hit opens its own group
      write_window('0);
      send_hit(5, 1, 0, 0);
      send_hit(5, 1, 0, 0);
      send_hit(5, 0, 1, 0);
      settle();

      write_window(WIN_MAX);
      send_hit(TIME_MIN, 1, 0, 0);
      send_hit(TIME_MAX, 1, 0, 0);
      send_hit(0, 0, 0, 0);
      send_hit(-1, 0, 1, 0);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin write_window(WIN_W'($urandom_range(1, 500))); idle_pct = 0; end
            1: begin write_window(WIN_MAX); idle_pct = 46; end
            2: begin write_window(WIN_W'($urandom_range(0, 32'h7FFF_FFFF))); idle_pct = 0; end
            default: begin write_window(WIN_W'($urandom_range(0, 3))); idle_pct = 8; end
         endcase
         sent = 0;
         while (sent < 100) send_frame(idle_pct, sent);
         settle();
      end

      if (sb.failures == 0 && sb.pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/htg_pkg.sv
hw/rtl/htg_ram.sv
hw/rtl/htg_match.sv
hw/rtl/hit_time_grouping.sv
sim/hit_time_grouping_test.sv
